### design/bab_pkg.sv
// block availability bitmap: shared types, func codes and defaults
// no dependencies; used by every module of the block
`default_nettype none

package bab_pkg;

    // default map size in bytes, eight blocks per byte
    localparam int unsigned MAP_BYTES_DEF = 64;
    localparam int unsigned BYTE_BITS     = 8;

    // func codes of a request beat
    localparam logic [2:0] FUNC_QUERY       = 3'd0;
    localparam logic [2:0] FUNC_MARK_AVAIL  = 3'd1;
    localparam logic [2:0] FUNC_MARK_UNAVL  = 3'd2;
    localparam logic [2:0] FUNC_CLEAR_ALL   = 3'd3;
    localparam logic [2:0] FUNC_FIND_AVAIL  = 3'd4;
    localparam logic [2:0] FUNC_FIND_OCCUP  = 3'd5;

    typedef struct packed {
        logic [2:0] func;
        logic [9:0] position;
    } bab_req_t;

    typedef struct packed {
        logic       available;
        logic       found;
        logic [8:0] found_index;
        logic       range_error;
    } bab_rsp_t;

    // result of the lowest-set-bit search over one byte
    typedef struct packed {
        logic       hit;
        logic [2:0] bit_idx;
    } bab_find_t;

endpackage

`default_nettype wire

### design/bab_mem.sv
// block availability bitmap: byte store, one write port, one registered read port
// depends on bab_pkg for the byte width
`default_nettype none

module bab_mem
    import bab_pkg::*;
#(
    parameter int unsigned DEPTH = MAP_BYTES_DEF,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire logic [BYTE_BITS-1:0] wr_data,
    input  wire logic [AW-1:0]        rd_addr,
    output logic      [BYTE_BITS-1:0] rd_data
);

    logic [BYTE_BITS-1:0] mem [DEPTH];
    logic [BYTE_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### design/bab_bitfind.sv
// block availability bitmap: lowest set bit of one byte, the shared search unit
// depends on bab_pkg for bab_find_t
`default_nettype none

module bab_bitfind
    import bab_pkg::*;
(
    input  wire logic [BYTE_BITS-1:0] bits,
    output bab_find_t                 find
);

    always_comb
    begin
        find = '0;
        // walk down so the lowest set bit wins
        for (int i = BYTE_BITS - 1; i >= 0; i--)
        begin
            if (bits[i])
            begin
                find.hit     = 1'b1;
                find.bit_idx = 3'(i);
            end
        end
    end

endmodule

`default_nettype wire

### design/block_availability_bitmap.sv
// Block availability bitmap, one bit per block held in a byte store of MAP_BYTES
// entries; block p sits in byte p/8 at bit p%8, a set bit meaning available.
// One request beat is taken at a time and gives one response beat. Query and
// the two marks read their byte, a mark writing it back, before the response; a
// position at or beyond MAP_BYTES*8 goes straight to the response with
// range_error and leaves the map alone. Clear all and both searches walk the
// store one byte per cycle, clear all through its write port and a search
// through its read port; a search stops early at the first matching byte. After
// reset the store is swept to zero while req_stall is high. Unused func codes
// answer with an all-zero response. found_index holds the low 9 bits of the
// block number.
// depends on bab_pkg, bab_mem, bab_bitfind
`default_nettype none

module block_availability_bitmap
    import bab_pkg::*;
#(
    parameter int unsigned MAP_BYTES = MAP_BYTES_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    // request channel
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire bab_req_t req,
    // response channel
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output bab_rsp_t      rsp
);

    localparam int unsigned AW       = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int unsigned MAP_BITS = MAP_BYTES * BYTE_BITS;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_BYTES - 1);

    // sequencer states
    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,  // zero sweep, after reset or on clear all
        ST_IDLE   = 6'b000010,  // ready for a request beat
        ST_MODIFY = 6'b000100,  // byte read back: query answer or write back
        ST_SCAN   = 6'b001000,  // one byte checked per cycle
        ST_DONE   = 6'b010000,  // response beat held until taken
        ST_SPARE  = 6'b100000   // never entered
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [2:0]           func_reg, func_next;
    logic [2:0]           bit_reg, bit_next;
    logic                 want_reg, want_next;     // search target: 1 available
    logic                 clr_cmd_reg, clr_cmd_next; // sweep was asked for by a beat
    bab_rsp_t             rsp_reg, rsp_next;

    logic                 wr_en;
    logic [BYTE_BITS-1:0] wr_data;
    logic [BYTE_BITS-1:0] rd_data;
    logic [BYTE_BITS-1:0] scan_bits;
    logic [BYTE_BITS-1:0] bit_mask;
    bab_find_t            find;
    logic                 pos_oor;
    logic [31:0]          pos_ext;
    logic [31:0]          hit_index;

    // byte store; read address is the next address so data lines up with addr_reg
    bab_mem #(
        .DEPTH (MAP_BYTES),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (addr_reg),
        .wr_data (wr_data),
        .rd_addr (addr_next),
        .rd_data (rd_data)
    );

    // shared search unit, occupied search looks at the inverted byte
    assign scan_bits = want_reg ? rd_data : ~rd_data;

    bab_bitfind u_find (
        .bits (scan_bits),
        .find (find)
    );

    assign pos_ext   = 32'(req.position);
    assign pos_oor   = (pos_ext >= MAP_BITS);
    assign bit_mask  = 8'(1) << bit_reg;
    assign hit_index = (32'(addr_reg) << 3) | 32'(find.bit_idx);

    always_comb
    begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        func_next    = func_reg;
        bit_next     = bit_reg;
        want_next    = want_reg;
        clr_cmd_next = clr_cmd_reg;
        rsp_next     = rsp_reg;
        wr_en        = 1'b0;
        wr_data      = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    addr_next  = '0;
                    rsp_next   = '0;
                    state_next = clr_cmd_reg ? ST_DONE : ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    rsp_next  = '0;
                    func_next = req.func;
                    bit_next  = req.position[2:0];
                    unique case (req.func)
                        FUNC_QUERY, FUNC_MARK_AVAIL, FUNC_MARK_UNAVL:
                        begin
                            if (pos_oor)
                            begin
                                rsp_next.range_error = 1'b1;
                                state_next           = ST_DONE;
                            end
                            else
                            begin
                                addr_next  = pos_ext[3 +: AW];
                                state_next = ST_MODIFY;
                            end
                        end
                        FUNC_CLEAR_ALL:
                        begin
                            addr_next    = '0;
                            clr_cmd_next = 1'b1;
                            state_next   = ST_CLEAR;
                        end
                        FUNC_FIND_AVAIL, FUNC_FIND_OCCUP:
                        begin
                            addr_next  = '0;
                            want_next  = (req.func == FUNC_FIND_AVAIL);
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_MODIFY:
            begin
                unique case (func_reg)
                    FUNC_MARK_AVAIL:
                    begin
                        wr_en   = 1'b1;
                        wr_data = rd_data | bit_mask;
                    end
                    FUNC_MARK_UNAVL:
                    begin
                        wr_en   = 1'b1;
                        wr_data = rd_data & ~bit_mask;
                    end
                    default:
                    begin
                        rsp_next.available = rd_data[bit_reg];
                    end
                endcase
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                if (find.hit)
                begin
                    rsp_next.found       = 1'b1;
                    rsp_next.found_index = hit_index[8:0];
                    addr_next            = '0;
                    state_next           = ST_DONE;
                end
                else if (addr_reg == LAST_ADDR)
                begin
                    addr_next  = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!rsp_stall)
                begin
                    clr_cmd_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            addr_reg    <= '0;
            clr_cmd_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            clr_cmd_reg <= clr_cmd_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        bit_reg  <= bit_next;
        want_reg <= want_next;
        rsp_reg  <= rsp_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = (state_reg == ST_DONE);
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // a pending response beat keeps the request side closed
    assert property (@(posedge clk) disable iff (!rst_n) rsp_valid |-> req_stall)
        else $error("request side open while a response is pending");

    // a range error never comes with a query or search answer
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.range_error) |-> (!rsp.available && !rsp.found))
        else $error("range error mixed with an answer");

    // a response without a hit reports index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.found) |-> (rsp.found_index == 9'd0))
        else $error("nonzero index without a hit");

    // a search beat starts the scan at byte zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall
            && (req.func == FUNC_FIND_AVAIL || req.func == FUNC_FIND_OCCUP))
        |=> (state_reg == ST_SCAN && addr_reg == '0))
        else $error("search did not start at the first byte");
`endif

endmodule

`default_nettype wire

### tb/tb_block_availability_bitmap.sv
// testbench for block_availability_bitmap: directed probe table, then random op streams
// checks every response beat against an in-bench copy of the availability map or a hand-typed answer
// depends on bab_pkg and the block_availability_bitmap rtl
`timescale 1ns / 100ps

module tb_block_availability_bitmap;
    import bab_pkg::*;

    localparam int unsigned MAP_BITS    = MAP_BYTES_DEF * BYTE_BITS;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned DRAIN_WAIT  = MAP_BYTES_DEF + 8;

    // func codes the block does not define, they must answer all zero
    localparam logic [2:0] FUNC_SPARE6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE7 = 3'd7;

    // one directed probe; pinned rows carry a response typed in by hand
    typedef struct packed {
        logic [2:0] func;
        logic [9:0] position;
        logic       pinned;
        logic       w_avail;
        logic       w_found;
        logic [8:0] w_index;
        logic       w_range;
    } probe_row_t;

    localparam int NUM_PROBES = 25;
    localparam probe_row_t PROBES [NUM_PROBES] = '{
        // fresh map: nothing available, everything occupied
        '{FUNC_QUERY,      10'd0,    1'b1, 1'b0, 1'b0, 9'd0, 1'b0},
        '{FUNC_FIND_AVAIL, 10'd0,    1'b1, 1'b0, 1'b0, 9'd0, 1'b0},
        '{FUNC_FIND_OCCUP, 10'd1023, 1'b1, 1'b0, 1'b1, 9'd0, 1'b0},
        // positions past the map flag an error and leave the map alone
        '{FUNC_QUERY,      10'd1023, 1'b1, 1'b0, 1'b0, 9'd0, 1'b1},
        '{FUNC_MARK_AVAIL, 10'd512,  1'b1, 1'b0, 1'b0, 9'd0, 1'b1},
        '{FUNC_MARK_UNAVL, 10'd1023, 1'b1, 1'b0, 1'b0, 9'd0, 1'b1},
        // top block of the map, then the bottom ones
        '{FUNC_MARK_AVAIL, 10'd511,  1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
        '{FUNC_QUERY,      10'd511,  1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
        '{FUNC_FIND_AVAIL, 10'd0,    1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
        '{FUNC_MARK_AVAIL, 10'd0,    1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
        '{FUNC_MARK_AVAIL, 10'd1,    1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
        '{FUNC_MARK_AVAIL, 10'd2,    1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
        // clearing bit 1 must keep bit 0 and bit 2 of the same byte
        '{FUNC_MARK_UNAVL, 10'd1,    1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
        '{FUNC_QUERY,      10'd0,    1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
        '{FUNC_QUERY,      10'd2,    1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
        '{FUNC_FIND_AVAIL, 10'd0,    1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
        '{FUNC_FIND_OCCUP, 10'd0,    1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
        '{FUNC_QUERY,      10'd512,  1'b1, 1'b0, 1'b0, 9'd0, 1'b1},
        '{FUNC_SPARE6,     10'd5,    1'b1, 1'b0, 1'b0, 9'd0, 1'b0},
        '{FUNC_SPARE7,     10'd1023, 1'b1, 1'b0, 1'b0, 9'd0, 1'b0},
        // clear ignores position, never flags an error
        '{FUNC_CLEAR_ALL,  10'd1023, 1'b1, 1'b0, 1'b0, 9'd0, 1'b0},
        '{FUNC_FIND_AVAIL, 10'd1023, 1'b1, 1'b0, 1'b0, 9'd0, 1'b0},
        '{FUNC_MARK_AVAIL, 10'd341,  1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
        '{FUNC_FIND_AVAIL, 10'd682,  1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
        '{FUNC_MARK_UNAVL, 10'd682,  1'b1, 1'b0, 1'b0, 9'd0, 1'b1}
    };

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    bab_req_t req;
    logic     rsp_valid;
    logic     rsp_stall;
    bab_rsp_t rsp;

    // bench copy of the availability map, byte p/8 bit p%8
    logic [7:0]  avail_bytes [MAP_BYTES_DEF];
    // responses owed by the block, oldest first
    bab_rsp_t    answer_q [$];

    // hand-typed response for the beat now on offer
    logic        pinned_now;
    bab_rsp_t    pinned_rsp;

    int unsigned idle_odds;      // percent chance per cycle/beat of starting an idle burst
    logic        long_hold_due;
    int unsigned err_count;
    int unsigned answers_seen;
    int unsigned cycle_count;

    block_availability_bitmap #(
        .MAP_BYTES (MAP_BYTES_DEF)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // applies one request to the bench map and returns the response it owes
    function automatic bab_rsp_t bitmap_answer(input bab_req_t r);
        bab_rsp_t    a;
        int unsigned p;
        int unsigned i;
        logic        want_bit;
        logic        hit;
        a   = '0;
        p   = r.position;
        hit = 1'b0;
        case (r.func)
            FUNC_QUERY, FUNC_MARK_AVAIL, FUNC_MARK_UNAVL:
            begin
                if (p >= MAP_BITS)
                    a.range_error = 1'b1;
                else if (r.func == FUNC_QUERY)
                    a.available = avail_bytes[p / BYTE_BITS][p % BYTE_BITS];
                else
                    avail_bytes[p / BYTE_BITS][p % BYTE_BITS] = (r.func == FUNC_MARK_AVAIL);
            end
            FUNC_CLEAR_ALL:
            begin
                for (i = 0; i < MAP_BYTES_DEF; i++)
                    avail_bytes[i] = 8'h00;
            end
            FUNC_FIND_AVAIL, FUNC_FIND_OCCUP:
            begin
                want_bit = (r.func == FUNC_FIND_AVAIL);
                // lowest block whose bit matches
                for (i = 0; i < MAP_BITS; i++)
                begin
                    if (!hit && avail_bytes[i / BYTE_BITS][i % BYTE_BITS] == want_bit)
                    begin
                        hit           = 1'b1;
                        a.found       = 1'b1;
                        a.found_index = i[8:0];
                    end
                end
            end
            default:
            begin
                // spare codes change nothing and answer zero
            end
        endcase
        return a;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < 100)
            $display("mismatch at response %0d, %s: got 0x%0h, want 0x%0h",
                     answers_seen, what, got, want);
        err_count++;
    endtask

    // offers one request beat and returns once it has been taken
    task automatic send_beat(input logic [2:0] f, input logic [9:0] p, input logic pin,
                             input bab_rsp_t want);
        int unsigned gap_len;
        gap_len = 0;
        if (idle_odds != 0 && $urandom_range(99, 0) < idle_odds)
            gap_len = $urandom_range(14, 1);
        @(negedge clk);
        if (gap_len != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap_len) @(negedge clk);
        end
        pinned_now   = pin;
        pinned_rsp   = want;
        req_valid   <= 1'b1;
        req.func    <= f;
        req.position <= p;
        // valid stays up after the accept; the end lowers it, a next call only for an idle gap
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    // mostly inside the map, now and then past it
    function automatic logic [9:0] pick_position();
        if ($urandom_range(99, 0) < 85)
            return 10'($urandom_range(MAP_BITS - 1, 0));
        return 10'($urandom_range(1023, 0));
    endfunction

    function automatic logic [2:0] pick_func();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 25) return FUNC_QUERY;
        if (roll < 45) return FUNC_MARK_AVAIL;
        if (roll < 65) return FUNC_MARK_UNAVL;
        if (roll < 67) return FUNC_CLEAR_ALL;
        if (roll < 80) return FUNC_FIND_AVAIL;
        if (roll < 93) return FUNC_FIND_OCCUP;
        if (roll < 97) return FUNC_SPARE6;
        return FUNC_SPARE7;
    endfunction

    // response side: random stall bursts plus one long hold-off
    initial
    begin : rsp_side
        int unsigned burst;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_due)
            begin
                // block fills with one request and must push back on req_stall
                long_hold_due = 1'b0;
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                rsp_stall <= 1'b0;
            end
            else if (idle_odds != 0 && $urandom_range(99, 0) < idle_odds)
            begin
                burst = $urandom_range(14, 1);
                rsp_stall <= 1'b1;
                repeat (burst) @(negedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    // sample both channels at the edge, check responses before queueing new ones
    always @(posedge clk)
    begin : watch
        bab_rsp_t calc;
        bab_rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                answers_seen++;
                if (answer_q.size() == 0)
                    report_mismatch("response with nothing owed", 32'(rsp), 32'd0);
                else
                begin
                    want = answer_q.pop_front();
                    if (rsp.available !== want.available)
                        report_mismatch("available", 32'(rsp.available), 32'(want.available));
                    if (rsp.found !== want.found)
                        report_mismatch("found", 32'(rsp.found), 32'(want.found));
                    if (rsp.found_index !== want.found_index)
                        report_mismatch("found_index", 32'(rsp.found_index),
                                        32'(want.found_index));
                    if (rsp.range_error !== want.range_error)
                        report_mismatch("range_error", 32'(rsp.range_error),
                                        32'(want.range_error));
                end
            end
            if (req_valid && !req_stall)
            begin
                // the bench map moves on pinned rows too
                calc = bitmap_answer(req);
                answer_q.push_back(pinned_now ? pinned_rsp : calc);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses owed", cycle_count,
                     answer_q.size());
            $display("[block_availability_bitmap] ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned order [MAP_BITS];
        int unsigned i;
        int unsigned j;
        int unsigned tmp;
        int unsigned k;
        probe_row_t  row;
        bab_rsp_t    want;
        logic [2:0]  f;

        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        pinned_now    = 1'b0;
        pinned_rsp    = '0;
        idle_odds     = 15;
        long_hold_due = 1'b0;
        err_count     = 0;
        answers_seen  = 0;
        cycle_count   = 0;
        for (i = 0; i < MAP_BYTES_DEF; i++)
            avail_bytes[i] = 8'h00;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // the clearing sweep after reset shows up as req_stall, no wait needed here

        // directed probes
        for (k = 0; k < NUM_PROBES; k++)
        begin
            row  = PROBES[k];
            want = '{available: row.w_avail, found: row.w_found,
                     found_index: row.w_index, range_error: row.w_range};
            send_beat(row.func, row.position, row.pinned, want);
        end

        // fill the whole map in shuffled order, searches and queries mixed in,
        // so the searches walk ever further and finally find nothing occupied
        idle_odds = 10;
        for (i = 0; i < MAP_BITS; i++)
            order[i] = i;
        for (i = MAP_BITS - 1; i > 0; i--)
        begin
            j        = $urandom_range(i, 0);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (i = 0; i < MAP_BITS; i++)
        begin
            send_beat(FUNC_MARK_AVAIL, 10'(order[i]), 1'b0, '0);
            if ($urandom_range(7, 0) == 0)
                send_beat($urandom_range(1, 0) ? FUNC_FIND_AVAIL : FUNC_FIND_OCCUP,
                          10'($urandom_range(1023, 0)), 1'b0, '0);
            if ($urandom_range(19, 0) == 0)
                send_beat(FUNC_QUERY, pick_position(), 1'b0, '0);
        end
        send_beat(FUNC_FIND_OCCUP, 10'($urandom_range(1023, 0)), 1'b0, '0);
        send_beat(FUNC_FIND_AVAIL, 10'($urandom_range(1023, 0)), 1'b0, '0);

        // free mix of every op, heavier idling, one long response hold-off
        idle_odds     = 25;
        long_hold_due = 1'b1;
        for (k = 0; k < 100; k++)
        begin
            f = pick_func();
            send_beat(f, pick_position(), 1'b0, '0);
        end

        // closing stretch at full rate
        idle_odds = 0;
        for (k = 0; k < 40; k++)
        begin
            f = pick_func();
            send_beat(f, pick_position(), 1'b0, '0);
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (answer_q.size() != 0) @(posedge clk);
        // catch any stray response after the last owed one
        repeat (DRAIN_WAIT) @(posedge clk);

        if (err_count == 0)
            $display("[block_availability_bitmap] OK");
        else
            $display("[block_availability_bitmap] ERROR");
        $finish;
    end

endmodule
